// ----- rtl/bsa_pkg.sv -----
// Shared constants and types for the bitmap slot allocator.
`default_nettype none

package bsa_pkg;

  // Build-time defaults
  localparam int unsigned WORD_BITS_DEF  = 32;
  localparam int unsigned SLOT_COUNT_DEF = 1024;

  // Fixed field widths
  localparam int unsigned CAP_W       = 11;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_e;

endpackage

`default_nettype wire

// ----- rtl/bsa_bitmap_ram.sv -----
// Bitmap word memory with per-word valid bits; unwritten words read as zero.
`default_nettype none

module bsa_bitmap_ram #(
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned ADDR_W = 5
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [WIDTH-1:0] rd_q;
  logic             rvld_q;

  // Storage array: write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem[raddr_i];
    end
  end

  // Track which words have been written since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rd_q : '0;

endmodule

`default_nettype wire

// ----- rtl/bitmap_slot_allocator.sv -----
// Top level of the first-fit bitmap slot allocator.
//
//  Port group   Dir  Contents (low bits first)
//  s_axis_*     in   tdata: slot_index[9:0], zero pad; tuser: req_type
//  m_axis_*     out  tdata: granted_slot[9:0], zero pad; tuser: status[1:0]
//  cfg_*        in   cfg_wdata_i: capacity_in_use[10:0], written when cfg_we_i
//
//  A request runs through an accept step, then a modify step. The accept step
//  picks the word (first clear entry of the per-word full flags for an allocate)
//  and issues the memory read; the modify step finds the bit, writes the word back
//  and loads the result, holding while the output register has an untaken word.
//  Reset clears the bitmap through per-word valid bits, so no clearing pass.
//  WORD_BITS must be a power of two.
`default_nettype none

module bitmap_slot_allocator
  import bsa_pkg::*;
#(
  parameter int unsigned WORD_BITS  = WORD_BITS_DEF,
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // request words
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // slot_index[9:0], pad
  input  wire logic                   s_axis_tuser,   // req_type
  // result words
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,   // granted_slot[9:0], pad
  output logic      [STATUS_W-1:0]    m_axis_tuser,   // status[1:0]
  // capacity register
  input  wire logic                   cfg_we_i,
  input  wire logic [CAP_W-1:0]       cfg_wdata_i
);

  localparam int unsigned WORD_COUNT = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WADDR_W    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int unsigned BIT_W      = $clog2(WORD_BITS);
  localparam int unsigned SPAN_W     = $clog2(WORD_COUNT * WORD_BITS);
  localparam int unsigned CMP_W      = ((SPAN_W > CAP_W) ? SPAN_W : CAP_W) + 1;

  typedef enum logic {
    S_IDLE,
    S_MOD
  } state_e;

  state_e                 state_q;
  logic [CAP_W-1:0]       cap_q;
  logic [WORD_COUNT-1:0]  full_q;
  logic                   req_q;
  logic                   skip_q;
  logic [WADDR_W-1:0]     waddr_q;
  logic [BIT_W-1:0]       bit_q;
  logic                   out_valid_q;
  logic [IDX_W-1:0]       out_slot_q;
  status_e                out_status_q;

  logic [CMP_W-1:0]       limit;
  logic [CMP_W-1:0]       idx_ext;
  logic                   accept;
  logic                   hit;
  logic [WADDR_W-1:0]     hit_w;
  logic [WADDR_W-1:0]     rd_addr;
  logic [WORD_BITS-1:0]   word;
  logic                   zf;
  logic [BIT_W-1:0]       zpos;
  logic [BIT_W-1:0]       pos;
  logic [CMP_W-1:0]       slot;
  logic                   alloc_ok;
  logic [WORD_BITS-1:0]   mask;
  logic [WORD_BITS-1:0]   wr_data;
  logic                   mem_we;
  logic                   advance;
  status_e                res_status;
  logic [IDX_W-1:0]       res_slot;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Clamp capacity to the built size
  assign limit = (CMP_W'(cap_q) > CMP_W'(SLOT_COUNT)) ? CMP_W'(SLOT_COUNT) : CMP_W'(cap_q);

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign idx_ext       = CMP_W'(s_axis_tdata[IDX_W-1:0]);

  // Pick the lowest word whose full flag is clear
  always_comb begin
    hit   = 1'b0;
    hit_w = '0;
    for (int i = WORD_COUNT - 1; i >= 0; i--) begin
      if (!full_q[i]) begin
        hit   = 1'b1;
        hit_w = WADDR_W'(i);
      end
    end
  end

  assign rd_addr = (s_axis_tuser == REQ_FREE) ? WADDR_W'(idx_ext >> BIT_W) : hit_w;

  bsa_bitmap_ram #(
    .DEPTH  (WORD_COUNT),
    .WIDTH  (WORD_BITS),
    .ADDR_W (WADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (word),
    .we_i    (mem_we),
    .waddr_i (waddr_q),
    .wdata_i (wr_data)
  );

  // Find the first clear bit counting down from the MSB
  always_comb begin
    zf   = 1'b0;
    zpos = '0;
    for (int p = WORD_BITS - 1; p >= 0; p--) begin
      if (!word[WORD_BITS-1-p]) begin
        zf   = 1'b1;
        zpos = BIT_W'(p);
      end
    end
  end

  assign slot     = (CMP_W'(waddr_q) << BIT_W) | CMP_W'(zpos);
  assign alloc_ok = (req_q == REQ_ALLOC) && !skip_q && zf && (slot < limit);
  assign pos      = (req_q == REQ_FREE) ? bit_q : zpos;
  assign mask     = WORD_BITS'(1) << (BIT_W'(WORD_BITS - 1) - pos);
  assign wr_data  = (req_q == REQ_FREE) ? (word & ~mask) : (word | mask);
  assign advance  = (state_q == S_MOD) && (!out_valid_q || m_axis_tready);
  assign mem_we   = advance && ((req_q == REQ_FREE) ? !skip_q : alloc_ok);

  // Result of the request in flight
  always_comb begin
    res_slot = '0;
    if (req_q == REQ_FREE) begin
      res_status = skip_q ? STATUS_RANGE : STATUS_DONE;
    end else if (alloc_ok) begin
      res_status = STATUS_DONE;
      res_slot   = slot[IDX_W-1:0];
    end else begin
      res_status = STATUS_FULL;
    end
  end

  // Sequencer, full flags and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      full_q       <= '0;
      req_q        <= REQ_ALLOC;
      skip_q       <= 1'b0;
      waddr_q      <= '0;
      bit_q        <= '0;
      out_valid_q  <= 1'b0;
      out_slot_q   <= '0;
      out_status_q <= STATUS_DONE;
    end else begin
      // Drop a taken word unless a new one loads in its place
      if (out_valid_q && m_axis_tready && !advance) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            req_q   <= s_axis_tuser;
            waddr_q <= rd_addr;
            bit_q   <= BIT_W'(idx_ext);
            skip_q  <= (s_axis_tuser == REQ_FREE) ? (idx_ext >= limit) : !hit;
            state_q <= S_MOD;
          end
        end
        S_MOD: begin
          if (advance) begin
            if (mem_we) begin
              full_q[waddr_q] <= &wr_data;
            end
            out_valid_q  <= 1'b1;
            out_slot_q   <= res_slot;
            out_status_q <= res_status;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_slot_q);
  assign m_axis_tuser  = out_status_q;

`ifndef SYNTHESIS
  // A new result loads only out of the modify step
  a_res_from_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_MOD))
    else $error("result appeared without a modify step");

  // An allocate write sets exactly one more bit
  a_alloc_one_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && req_q == REQ_ALLOC) |-> ($countones(wr_data) == $countones(word) + 1))
    else $error("allocate write did not set exactly one bit");

  // A granted word was never marked full
  a_alloc_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && req_q == REQ_ALLOC) |-> !full_q[waddr_q])
    else $error("allocate wrote a word flagged full");

  // Accepted requests enter the modify step next
  a_accept_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_MOD))
    else $error("accepted request did not reach the modify step");
`endif

endmodule

`default_nettype wire

// ----- bench/bsa_checker.sv -----
// Result checker for the bitmap slot allocator: tracks the bitmap and compares results.
`timescale 1ns / 1ps

module bsa_checker
  import bsa_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // slot_index[9:0], pad
  input  logic                   s_axis_tuser,   // req_type
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // granted_slot[9:0], pad
  input  logic [STATUS_W-1:0]    m_axis_tuser,   // status[1:0]
  input  logic                   cfg_we_i,
  input  logic [CAP_W-1:0]       cfg_wdata_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  localparam int unsigned MAP_WORDS = SLOT_COUNT_DEF / WORD_BITS_DEF;

  typedef struct packed {
    logic [IDX_W-1:0] slot;
    status_e          status;
  } grant_t;

  // Shadow copy of the allocator state
  logic [WORD_BITS_DEF-1:0] slot_map [MAP_WORDS];
  logic [CAP_W-1:0]         capacity_q;
  grant_t                   expected_grants [$];

  // Apply one request to the shadow bitmap and return the result it yields
  function automatic grant_t serve_request(req_e kind, logic [IDX_W-1:0] slot);
    grant_t      res;
    int unsigned limit;
    int unsigned word;
    int unsigned pos;
    int unsigned found;
    limit = (capacity_q > SLOT_COUNT_DEF) ? SLOT_COUNT_DEF : capacity_q;
    res.slot = '0;
    res.status = STATUS_DONE;
    if (kind == REQ_FREE) begin
      // Slot 0 of a word sits in its MSB
      if (slot >= limit) begin
        res.status = STATUS_RANGE;
      end else begin
        slot_map[slot / WORD_BITS_DEF][WORD_BITS_DEF - 1 - slot % WORD_BITS_DEF] = 1'b0;
      end
    end else begin
      res.status = STATUS_FULL;
      word = 0;
      while (word < MAP_WORDS && &slot_map[word]) word++;
      if (word < MAP_WORDS) begin
        pos = 0;
        while (slot_map[word][WORD_BITS_DEF - 1 - pos]) pos++;
        found = word * WORD_BITS_DEF + pos;
        // First free slot past the capacity leaves the bitmap alone
        if (found < limit) begin
          slot_map[word][WORD_BITS_DEF - 1 - pos] = 1'b1;
          res.slot = IDX_W'(found);
          res.status = STATUS_DONE;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    if (!rst_ni) begin
      foreach (slot_map[w]) slot_map[w] = '0;
      capacity_q = CAP_RESET;
      expected_grants.delete();
      fail_count_o = 0;
    end else begin
      // Compare a taken result word with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_grants.size() == 0) begin
          $display("%0t: result word with no request outstanding: slot %0d status %0d",
                   $time, m_axis_tdata, m_axis_tuser);
          fail_count_o++;
        end else begin
          want = expected_grants.pop_front();
          if (m_axis_tdata !== OUT_TDATA_W'(want.slot)) begin
            $display("%0t: granted_slot mismatch: expected %0d, actual %0d",
                     $time, want.slot, m_axis_tdata);
            fail_count_o++;
          end
          if (m_axis_tuser !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, m_axis_tuser);
            fail_count_o++;
          end
        end
      end
      // Predict the result of an accepted request word
      if (s_axis_tvalid && s_axis_tready) begin
        expected_grants.push_back(serve_request(req_e'(s_axis_tuser),
                                                s_axis_tdata[IDX_W-1:0]));
      end
      if (cfg_we_i) capacity_q = cfg_wdata_i;
    end
    pending_o = expected_grants.size();
  end

endmodule

// ----- bench/bitmap_slot_allocator_tb.sv -----
// Testbench top for the bitmap slot allocator: stimulus, back pressure and verdict.
`timescale 1ns / 1ps

module bitmap_slot_allocator_tb;
  import bsa_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned SLOT_LAST   = SLOT_COUNT_DEF - 1;
  localparam int unsigned CAP_MAX     = (1 << CAP_W) - 1;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = REQ_ALLOC;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;
  logic                   cfg_we_i      = 1'b0;
  logic [CAP_W-1:0]       cfg_wdata_i   = '0;

  int          fail_count;
  int          pending;
  int unsigned idle_cycles = 0;
  int unsigned capacity    = CAP_RESET;
  bit          back_to_back = 1'b0;

  bitmap_slot_allocator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  bsa_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap(bit steady);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Frees aim mostly inside the capacity and at its edge
  function automatic int unsigned pick_free_slot();
    int unsigned lim;
    int unsigned hi;
    int unsigned r;
    lim = (capacity > SLOT_COUNT_DEF) ? SLOT_COUNT_DEF : capacity;
    hi = (lim < SLOT_COUNT_DEF) ? lim : SLOT_LAST;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, hi);
    if (r < 85) return (lim == 0) ? 0 : $urandom_range(lim - 1, hi);
    return $urandom_range(0, SLOT_LAST);
  endfunction

  function automatic int unsigned pick_capacity();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1;
      2, 3:    return $urandom_range(2, 40);
      4:       return $urandom_range(30, 70);
      5:       return SLOT_COUNT_DEF;
      6:       return CAP_MAX;
      7:       return $urandom_range(SLOT_COUNT_DEF + 1, CAP_MAX - 1);
      default: return $urandom_range(0, CAP_MAX);
    endcase
  endfunction

  // Present one request word and hold it until accepted
  task automatic post_request(req_e kind, int unsigned slot);
    int unsigned gap;
    gap = pick_gap(back_to_back);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(slot);
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop sending and wait for every outstanding result word
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic set_capacity(int unsigned value);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CAP_W'(value);
    capacity = value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_phase(int unsigned count, bit hold_mid);
    int unsigned alloc_pct;
    alloc_pct = $urandom_range(30, 75);
    back_to_back = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < count; i++) begin
      if (hold_mid && i == count / 2) drain_results();
      if ($urandom_range(1, 100) <= alloc_pct) begin
        post_request(REQ_ALLOC, $urandom_range(0, SLOT_LAST));
      end else begin
        post_request(REQ_FREE, pick_free_slot());
      end
    end
    back_to_back = 1'b0;
  endtask

  // Result side: stretches of steady ready between random stalls
  initial begin
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(30, 150)) begin
          @(negedge clk_i);
          m_axis_tready <= 1'b1;
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          @(negedge clk_i);
          m_axis_tready <= 1'b1;
        end
        repeat (pick_gap(1'b0)) begin
          @(negedge clk_i);
          m_axis_tready <= 1'b0;
        end
      end
    end
  end

  // Abort when neither side moves a word for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    @(posedge rst_ni);

    // Basic allocate and free at the reset capacity
    post_request(REQ_ALLOC, 0);
    post_request(REQ_ALLOC, SLOT_LAST);
    post_request(REQ_FREE, 0);
    post_request(REQ_FREE, 0);           // already free
    post_request(REQ_ALLOC, 0);
    post_request(REQ_FREE, SLOT_LAST);   // top slot, never taken
    post_request(REQ_ALLOC, 0);

    // Zero capacity: nothing to hand out, every free out of range
    set_capacity(0);
    post_request(REQ_ALLOC, 0);
    post_request(REQ_FREE, 0);

    // Capacity above the built size acts as the built size
    set_capacity(CAP_MAX);
    post_request(REQ_FREE, SLOT_LAST);
    post_request(REQ_ALLOC, 0);

    // First free slot lies past a small capacity
    set_capacity(4);
    post_request(REQ_ALLOC, 0);
    post_request(REQ_FREE, 4);
    post_request(REQ_FREE, 1);
    post_request(REQ_ALLOC, 0);
    post_request(REQ_FREE, 1000);
    set_capacity(SLOT_COUNT_DEF);

    for (int p = 0; p < 2; p++) begin
      set_capacity(pick_capacity());
      random_phase(15, p == 0 || $urandom_range(0, 3) == 0);
    end

    // Fill the whole bitmap, then ask past the last word
    set_capacity(CAP_MAX);
    back_to_back = 1'b1;
    repeat (SLOT_COUNT_DEF + 4) post_request(REQ_ALLOC, $urandom_range(0, SLOT_LAST));
    back_to_back = 1'b0;

    // Punch holes into the full bitmap at varying capacities
    for (int p = 0; p < 3; p++) begin
      set_capacity(pick_capacity());
      random_phase(15, $urandom_range(0, 3) == 0);
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- bitmap_slot_allocator.f -----
rtl/bsa_pkg.sv
rtl/bsa_bitmap_ram.sv
rtl/bitmap_slot_allocator.sv
bench/bsa_checker.sv
bench/bitmap_slot_allocator_tb.sv
